@@ src/trimming_url_form_encoder_assert.svh @@
// Assertion macros used by the top-level encoder file.
`ifndef TRIMMING_URL_FORM_ENCODER_ASSERT_SVH
`define TRIMMING_URL_FORM_ENCODER_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define TUFE_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define TUFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/tufe_pkg.sv @@
package tufe_pkg;

    typedef struct packed {
        logic [7:0] chr;
        logic       last;
        logic       term;
        logic       ovf;
    } t_enc_req;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FLUSH = 3'b010,
        S_CHAR  = 3'b100
    } t_state;

    typedef enum logic [1:0] {
        P_FIRST = 2'd0,
        P_HI    = 2'd1,
        P_LO    = 2'd2
    } t_phase;

    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [3:0] NIBBLE_MASK = 4'hf;

    function automatic logic is_plain(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h7a) ||
               (b >= 8'h41 && b <= 8'h5a) || b == 8'h2d || b == 8'h5f ||
               b == 8'h2e || b == 8'h7e;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        logic [3:0] v;
        v = n & NIBBLE_MASK;
        if (v < 4'd10) begin
            return 8'h30 + {4'd0, v};
        end
        return 8'h57 + {4'd0, v};
    endfunction

    // Bit 3 flags whitespace; bits 2:0 carry the stored code.
    function automatic logic [3:0] ws_code(input logic [7:0] b);
        case (b)
            8'h20:   return 4'b1000;
            8'h09:   return 4'b1001;
            8'h0a:   return 4'b1010;
            8'h0b:   return 4'b1011;
            8'h0c:   return 4'b1100;
            8'h0d:   return 4'b1101;
            default: return 4'b0000;
        endcase
    endfunction

    function automatic logic [7:0] ws_char(input logic [2:0] c);
        case (c)
            3'd1:    return 8'h09;
            3'd2:    return 8'h0a;
            3'd3:    return 8'h0b;
            3'd4:    return 8'h0c;
            3'd5:    return 8'h0d;
            default: return CH_SPACE;
        endcase
    endfunction

endpackage

@@ src/tufe_ws_ram.sv @@
module tufe_ws_ram
    import tufe_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [2:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [2:0]    o_rdata
);

    logic [2:0] r_mem [DEPTH];
    logic [2:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/tufe_char_enc.sv @@
module tufe_char_enc
    import tufe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    input  t_enc_req   i_req,
    output logic       o_req_ready,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_char,
    output logic       o_last_of_run,
    output logic       o_terminator,
    output logic       o_overflowed
);

    logic     r_busy;
    t_enc_req r_req;
    t_phase   r_phase;
    logic     r_ovalid;
    logic [7:0] r_ochar;
    logic     r_olast, r_oterm, r_oovf;

    logic       fire, final_ch, plain, space;
    logic [7:0] n_char;

    assign plain = is_plain(r_req.chr);
    assign space = (r_req.chr == CH_SPACE);
    assign fire  = r_busy && (!r_ovalid || i_ready);

    always_comb begin
        n_char   = CH_PERCENT;
        final_ch = 1'b0;
        if (r_req.term) begin
            n_char   = 8'd0;
            final_ch = 1'b1;
        end else begin
            case (r_phase)
                P_FIRST: begin
                    if (plain) begin
                        n_char   = r_req.chr;
                        final_ch = 1'b1;
                    end else if (space) begin
                        n_char   = CH_PLUS;
                        final_ch = 1'b1;
                    end
                end
                P_HI: n_char = hex_digit(r_req.chr[7:4]);
                P_LO: begin
                    n_char   = hex_digit(r_req.chr[3:0]);
                    final_ch = 1'b1;
                end
                default: n_char = CH_PERCENT;
            endcase
        end
    end

    // A new word may be taken in the cycle that the current one finishes.
    assign o_req_ready = !r_busy || (fire && final_ch);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
            r_phase  <= P_FIRST;
        end else begin
            if (i_req_valid && o_req_ready) begin
                r_busy  <= 1'b1;
                r_phase <= P_FIRST;
            end else if (fire && final_ch) begin
                r_busy <= 1'b0;
            end else if (fire) begin
                r_phase <= (r_phase == P_FIRST) ? P_HI : P_LO;
            end
            if (fire) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req_valid && o_req_ready) begin
            r_req <= i_req;
        end
        if (fire) begin
            r_ochar <= n_char;
            r_olast <= r_req.last && final_ch;
            r_oterm <= r_req.term;
            r_oovf  <= r_req.term && r_req.ovf;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_out_char    = r_ochar;
    assign o_last_of_run = r_olast;
    assign o_terminator  = r_oterm;
    assign o_overflowed  = r_oovf;

endmodule

@@ src/trimming_url_form_encoder.sv @@
// Flow: an accepted byte is registered in the character encoder, then in its output register;
// held whitespace is first read from the pending memory and flushed ahead of it, and a held
// whitespace byte gives no word when accepted. Throughput: one output word per cycle while the
// receiver is ready, so a plain byte gives one word and an escaped byte three; a flush gives one
// word per held space and three per other held whitespace byte. No new byte is taken meanwhile.
// Reset: synchronous, active low; clears the control state. The memory is not cleared.
`include "trimming_url_form_encoder_assert.svh"

module trimming_url_form_encoder
    import tufe_pkg::*;
#(
    parameter int PENDING_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_byte,
    input  logic       i_end_marker,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_char,
    output logic       o_last_of_run,
    output logic       o_terminator,
    output logic       o_overflowed
);

    localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int CW = $clog2(PENDING_DEPTH + 1);

    t_state        r_state, n_state;
    logic          r_skip, n_skip;
    logic          r_ovf, n_ovf;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [7:0]    r_byte;

    logic          accept, enc_ready, req_valid, we;
    t_enc_req      req;
    logic [3:0]    wsc;
    logic [2:0]    rdata;
    logic          flush_end;

    assign wsc       = ws_code(i_char_byte);
    assign o_ready   = (r_state == S_IDLE) && enc_ready;
    assign accept    = i_valid && o_ready;
    assign flush_end = (r_idx == CW'(r_count - CW'(1)));

    always_comb begin
        n_state   = r_state;
        n_skip    = r_skip;
        n_ovf     = r_ovf;
        n_count   = r_count;
        n_idx     = r_idx;
        req_valid = 1'b0;
        req       = '{chr: i_char_byte, last: 1'b1, term: 1'b0, ovf: 1'b0};
        we        = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_end_marker) begin
                        req_valid = 1'b1;
                        req       = '{chr: 8'd0, last: 1'b1, term: 1'b1, ovf: r_ovf};
                        n_skip    = 1'b1;
                        n_ovf     = 1'b0;
                        n_count   = '0;
                    end else if (wsc[3]) begin
                        if (!r_skip) begin
                            if (r_count < CW'(PENDING_DEPTH)) begin
                                we      = 1'b1;
                                n_count = CW'(r_count + CW'(1));
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                    end else begin
                        n_skip = 1'b0;
                        if (r_count == '0) begin
                            req_valid = 1'b1;
                        end else begin
                            // Start the walk: entry 0 is read this cycle.
                            n_idx   = '0;
                            n_state = S_FLUSH;
                        end
                    end
                end
            end
            S_FLUSH: begin
                req = '{chr: ws_char(rdata), last: 1'b0, term: 1'b0, ovf: 1'b0};
                if (enc_ready) begin
                    req_valid = 1'b1;
                    if (flush_end) begin
                        n_state = S_CHAR;
                    end else begin
                        n_idx = CW'(r_idx + CW'(1));
                    end
                end
            end
            S_CHAR: begin
                req = '{chr: r_byte, last: 1'b1, term: 1'b0, ovf: 1'b0};
                if (enc_ready) begin
                    req_valid = 1'b1;
                    n_count   = '0;
                    n_idx     = '0;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_skip  <= 1'b1;
            r_ovf   <= 1'b0;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_skip  <= n_skip;
            r_ovf   <= n_ovf;
            r_count <= n_count;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_char_byte;
        end
    end

    // The read address is the next index, so the read data always matches r_idx.
    // Writes occur only while idle, so no access overlaps the walk.
    tufe_ws_ram #(
        .DEPTH (PENDING_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (wsc[2:0]),
        .i_raddr (n_idx[AW-1:0]),
        .o_rdata (rdata)
    );

    tufe_char_enc u_enc (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (req_valid),
        .i_req         (req),
        .o_req_ready   (enc_ready),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_char    (o_out_char),
        .o_last_of_run (o_last_of_run),
        .o_terminator  (o_terminator),
        .o_overflowed  (o_overflowed)
    );

    `TUFE_ASSERT_ALWAYS(a_count_bound, r_count <= CW'(PENDING_DEPTH), "pending count over depth")
    `TUFE_ASSERT_ALWAYS(a_flush_index,
        (r_state != S_FLUSH) || (r_count != '0 && r_idx < r_count), "flush index out of range")
    `TUFE_ASSERT_ALWAYS(a_term_last, !(o_valid && o_terminator) || o_last_of_run,
        "terminator word not last")
    `TUFE_ASSERT_NEXT(a_char_done, r_state == S_CHAR && enc_ready,
        r_state == S_IDLE && r_count == '0, "flush did not return to idle")

endmodule

@@ verif/tb_trimming_url_form_encoder.sv @@
module tb_trimming_url_form_encoder;

    localparam int PENDING_DEPTH = 16;
    localparam int CLK_HALF      = 10;
    localparam int IDLE_LIMIT    = 4000;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_WORDS  = 190;
    localparam int DRAIN_CYCLES  = 16;

    typedef struct packed {
        logic [7:0] chr;
        logic       last;
        logic       term;
        logic       ovf;
    } enc_char_t;

    // Keeps its own copy of the trimming state and the queue of encoded
    // characters still owed by the block.
    class form_encoding_board;
        bit          at_start;
        int unsigned held;
        logic [7:0]  held_ws[PENDING_DEPTH];
        bit          dropped;
        enc_char_t   owed[$];
        int unsigned n_chars;
        int unsigned n_strings;
        int unsigned n_overflows;

        function new();
            n_chars     = 0;
            n_strings   = 0;
            n_overflows = 0;
            restart();
        endfunction

        function void restart();
            at_start = 1'b1;
            held     = 0;
            dropped  = 1'b0;
        endfunction

        function bit is_blank(logic [7:0] b);
            return b == 8'h20 || b == 8'h09 || b == 8'h0a || b == 8'h0b ||
                   b == 8'h0c || b == 8'h0d;
        endfunction

        function bit is_unreserved(logic [7:0] b);
            return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5a) ||
                   (b >= 8'h61 && b <= 8'h7a) || b == 8'h2d || b == 8'h5f ||
                   b == 8'h2e || b == 8'h7e;
        endfunction

        // Lower-case hex: '0'..'9' then 'a'..'f'.
        function logic [7:0] hex_char(logic [3:0] n);
            if (n < 4'd10) begin
                return 8'h30 + {4'h0, n};
            end
            return 8'h61 + {4'h0, n} - 8'd10;
        endfunction

        function void owe(logic [7:0] c);
            enc_char_t e;
            e.chr  = c;
            e.last = 1'b0;
            e.term = 1'b0;
            e.ovf  = 1'b0;
            owed.push_back(e);
        endfunction

        function void owe_encoded(logic [7:0] b);
            if (is_unreserved(b)) begin
                owe(b);
            end else if (b == 8'h20) begin
                owe(8'h2b);
            end else begin
                owe(8'h25);
                owe(hex_char(b[7:4]));
                owe(hex_char(b[3:0]));
            end
        endfunction

        function void note_input(logic [7:0] b, logic e);
            enc_char_t tail;
            if (e) begin
                tail.chr  = 8'h00;
                tail.last = 1'b1;
                tail.term = 1'b1;
                tail.ovf  = dropped;
                owed.push_back(tail);
                n_strings++;
                if (dropped) begin
                    n_overflows++;
                end
                restart();
                return;
            end
            if (is_blank(b)) begin
                if (at_start) begin
                    return;
                end
                if (held < PENDING_DEPTH) begin
                    held_ws[held] = b;
                    held++;
                end else begin
                    dropped = 1'b1;
                end
                return;
            end
            at_start = 1'b0;
            for (int unsigned i = 0; i < held; i++) begin
                owe_encoded(held_ws[i]);
            end
            held = 0;
            owe_encoded(b);
            tail = owed.pop_back();
            tail.last = 1'b1;
            owed.push_back(tail);
        endfunction

        // Returns an empty string when the word matches the oldest owed character.
        function string check_result(logic [7:0] c, logic l, logic t, logic o);
            enc_char_t want;
            if (owed.size() == 0) begin
                return $sformatf("unexpected word: char %02h last %0b term %0b ovf %0b",
                                 c, l, t, o);
            end
            want = owed.pop_front();
            n_chars++;
            if (c !== want.chr || l !== want.last || t !== want.term || o !== want.ovf) begin
                return $sformatf("word %0d: got %02h %0b %0b %0b, wanted %02h %0b %0b %0b",
                                 n_chars, c, l, t, o, want.chr, want.last, want.term, want.ovf);
            end
            return "";
        endfunction

        function int outstanding();
            return owed.size();
        endfunction
    endclass

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic [7:0] i_char_byte  = 8'h00;
    logic       i_end_marker = 1'b0;
    logic       i_ready      = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_out_char;
    logic       o_last_of_run;
    logic       o_terminator;
    logic       o_overflowed;

    form_encoding_board board = new();

    int unsigned mismatches   = 0;
    int unsigned words_in     = 0;
    int unsigned idle_cycles  = 0;
    int unsigned burst_left   = 1;
    int unsigned random_words = 0;
    int unsigned holds_done   = 0;
    bit          hold_off_req = 1'b0;

    trimming_url_form_encoder #(
        .PENDING_DEPTH(PENDING_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_char_byte   (i_char_byte),
        .i_end_marker  (i_end_marker),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_char    (o_out_char),
        .o_last_of_run (o_last_of_run),
        .o_terminator  (o_terminator),
        .o_overflowed  (o_overflowed)
    );

    initial begin
        forever begin
            #CLK_HALF i_clk = ~i_clk;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        mismatches++;
    endtask

    // Inputs and outputs are noted in one process so that a word accepted on
    // the same edge as a result is always seen first.
    always @(posedge i_clk) begin : monitor
        string verdict;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                board.note_input(i_char_byte, i_end_marker);
                words_in++;
            end
            if (o_valid && i_ready) begin
                verdict = board.check_result(o_out_char, o_last_of_run, o_terminator,
                                             o_overflowed);
                if (verdict.len() != 0) begin
                    report_mismatch(verdict);
                end
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timed out with %0d characters still owed.", board.outstanding());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // The receiver changes its stall pattern every so often; on request it holds
    // off for a long stretch so that the block backs up.
    initial begin : receiver
        int unsigned rx_cycle;
        int unsigned held_cycles;
        rx_cycle = 0;
        forever begin
            @(negedge i_clk);
            rx_cycle++;
            if (hold_off_req) begin
                i_ready <= 1'b0;
                for (held_cycles = 0; held_cycles < HOLD_CYCLES; held_cycles++) begin
                    @(negedge i_clk);
                end
                hold_off_req = 1'b0;
                holds_done++;
            end else begin
                case ((rx_cycle / 150) % 4)
                    0:       i_ready <= 1'b1;
                    1:       i_ready <= 1'($urandom_range(0, 1));
                    2:       i_ready <= ($urandom_range(0, 3) == 0);
                    default: i_ready <= (rx_cycle % 5 != 0);
                endcase
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, or after a gap with valid low.
    task automatic offer(input logic [7:0] b, input logic e = 1'b0);
        i_valid      <= 1'b1;
        i_char_byte  <= b;
        i_end_marker <= e;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        @(negedge i_clk);
        burst_left--;
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            burst_left = $urandom_range(1, 30);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (board.outstanding() != 0);
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 5))
            0:       return 8'h20;
            1:       return 8'h09;
            2:       return 8'h0a;
            3:       return 8'h0b;
            4:       return 8'h0c;
            default: return 8'h0d;
        endcase
    endfunction

    function automatic logic [7:0] pick_unreserved();
        case ($urandom_range(0, 3))
            0:       return 8'h61 + 8'($urandom_range(0, 25));
            1:       return 8'h41 + 8'($urandom_range(0, 25));
            2:       return 8'h30 + 8'($urandom_range(0, 9));
            default: begin
                case ($urandom_range(0, 3))
                    0:       return 8'h2d;
                    1:       return 8'h5f;
                    2:       return 8'h2e;
                    default: return 8'h7e;
                endcase
            end
        endcase
    endfunction

    // One string with random content. With with_overflow set, the second token
    // is an inner run longer than the pending buffer.
    task automatic send_random_string(input bit with_overflow);
        int unsigned n_tok;
        int unsigned kind;
        int unsigned run;
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) offer(pick_blank());
        end
        n_tok = $urandom_range(0, 12);
        if (with_overflow && n_tok < 3) begin
            n_tok = 3;
        end
        for (int unsigned t = 0; t < n_tok; t++) begin
            kind = $urandom_range(0, 9);
            if ($urandom_range(0, 7) == 0) begin
                run = $urandom_range(15, 20);
            end else begin
                run = $urandom_range(1, 3);
            end
            if (with_overflow) begin
                kind = (t == 1) ? 0 : 4;
                run  = (t == 1) ? PENDING_DEPTH + 2 : run;
            end
            if (kind < 3) begin
                repeat (run) offer(pick_blank());
                random_words += run;
            end else if (kind < 6) begin
                offer(pick_unreserved());
                random_words++;
            end else begin
                offer(8'($urandom_range(0, 255)));
                random_words++;
            end
        end
        offer(8'($urandom_range(0, 255)), 1'b1);
        random_words++;
    endtask

    initial begin : stimulus
        bit pressed;
        bit paused;
        pressed = 1'b0;
        paused  = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty string, then leading whitespace that must vanish.
        offer(8'h00, 1'b1);
        offer(8'h20);
        offer(8'h09);
        // Unreserved characters pass unchanged.
        offer(8'h61);
        offer(8'h41);
        offer(8'h30);
        offer(8'h2d);
        offer(8'h5f);
        offer(8'h2e);
        offer(8'h7e);
        // Inner run of all six whitespace kinds, flushed by a zero byte.
        offer(8'h20);
        offer(8'h09);
        offer(8'h0a);
        offer(8'h0b);
        offer(8'h0c);
        offer(8'h0d);
        offer(8'h00);
        // Escapes at the top of the byte range and for reserved punctuation.
        offer(8'hff);
        offer(8'h80);
        offer(8'h25);
        offer(8'h2b);
        offer(8'h7f);
        // Trailing whitespace is discarded; the byte on the end marker is ignored.
        offer(8'h20);
        offer(8'h0d);
        offer(8'h5a, 1'b1);
        wait_drained();

        send_random_string(1'b1);
        while (random_words < RANDOM_WORDS) begin
            if (!pressed && random_words >= 80) begin
                pressed      = 1'b1;
                hold_off_req = 1'b1;
                repeat (40) offer(8'($urandom_range(0, 255)) | 8'h80);
                offer(8'h00, 1'b1);
                random_words += 41;
            end else if (!paused && random_words >= 160) begin
                paused = 1'b1;
                wait_drained();
            end else begin
                send_random_string(1'b0);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        $display("Covered %0d input words over %0d strings, %0d encoded characters checked.",
                 words_in, board.n_strings, board.n_chars);
        $display("Strings with overflow: %0d; long receiver hold-offs: %0d.",
                 board.n_overflows, holds_done);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
